[sv/wvnc_pkg.sv]
// ----------------------------------------------------------------------------
// Windowed variance classifier package
// Shared sizes, types and codes for the windowed variance classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wvnc_pkg;

  localparam int unsigned WINDOW_LENGTH = 32;
  localparam int unsigned COORD_BITS    = 12;
  localparam int unsigned THR_BITS      = 24;
  localparam int unsigned CFG_IDX_BITS  = 4;

  localparam int unsigned CntW    = $clog2(WINDOW_LENGTH + 1);
  localparam int unsigned NW      = $clog2(WINDOW_LENGTH + 1);
  localparam int unsigned SumW    = COORD_BITS + $clog2(WINDOW_LENGTH);
  localparam int unsigned SqrW    = 2 * COORD_BITS;
  localparam int unsigned SumSqW  = SqrW + $clog2(WINDOW_LENGTH);
  localparam int unsigned Sum2W   = 2 * SumW;
  localparam int unsigned CmpW    = 2 * COORD_BITS + 2 * NW + THR_BITS + 1;
  localparam int unsigned RhsScale = WINDOW_LENGTH * (WINDOW_LENGTH - 1);

  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic [CntW-1:0]         cnt_t;
  typedef logic [SumW-1:0]         sum_t;
  typedef logic [SqrW-1:0]         sqr_t;
  typedef logic [SumSqW-1:0]       sum_sq_t;
  typedef logic [Sum2W-1:0]        sum2_t;
  typedef logic [CmpW-1:0]         cmp_t;
  typedef logic [THR_BITS-1:0]     thr_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_NO   = 2'd1,
    VERDICT_YES  = 2'd2
  } verdict_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_THRESHOLD_X = 4'd0,
    CFG_THRESHOLD_Y = 4'd1
  } cfg_reg_e;

  localparam thr_t ThrReset = THR_BITS'(100);

endpackage

[sv/wvnc_axis_test.sv]
// ----------------------------------------------------------------------------
// Axis variance test
// Registers the scaled sum of squares, the squared sum and the scaled
// threshold of one axis, then compares N*sum_sq against sum^2 + thr*N*(N-1).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wvnc_axis_test (
  input  logic            clk_i,
  input  logic            load_i,
  input  wvnc_pkg::sum_t    sum_i,
  input  wvnc_pkg::sum_sq_t sum_sq_i,
  input  wvnc_pkg::thr_t    thr_i,
  output logic            exceeds_o
);
  import wvnc_pkg::*;

  cmp_t  lhs_d, lhs_q;
  sum2_t sq_d, sq_q;
  cmp_t  rhs_d, rhs_q;

  assign lhs_d = cmp_t'(sum_sq_i) * cmp_t'(WINDOW_LENGTH);
  assign sq_d  = sum2_t'(sum_i) * sum2_t'(sum_i);
  assign rhs_d = cmp_t'(thr_i) * cmp_t'(RhsScale);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lhs_q <= lhs_d;
      sq_q  <= sq_d;
      rhs_q <= rhs_d;
    end
  end

  assign exceeds_o = lhs_q > (cmp_t'(sq_q) + rhs_q);

endmodule

[sv/windowed_variance_nod_classifier_unit.sv]
// ----------------------------------------------------------------------------
// Windowed variance nod classifier
// Each item passes through a four-register pipeline (input, accumulate,
// square, result) at one item per cycle while out_stall_i is low;
// stages advance into free slots.
// Reset clears the window sums, the count and all valid flags, and sets
// both thresholds to 100.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module windowed_variance_nod_classifier_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  face_found_i,
  input  wvnc_pkg::coord_t      face_x_i,
  input  wvnc_pkg::coord_t      face_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            verdict_o,
  output logic                  window_done_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wvnc_pkg::cfg_idx_t    cfg_index_i,
  input  wvnc_pkg::thr_t        cfg_data_i
);
  import wvnc_pkg::*;

  thr_t thr_x_q, thr_y_q;

  logic   s1_v_q, s1_found_q;
  coord_t s1_x_q, s1_y_q;

  cnt_t    cnt_d, cnt_q;
  sum_t    acc_x_d, acc_x_q, acc_y_d, acc_y_q;
  sum_sq_t acc_sqx_d, acc_sqx_q, acc_sqy_d, acc_sqy_q;

  logic    s2_v_q, s2_last_d, s2_last_q;
  sum_t    s2_x_q, s2_y_q;
  sum_sq_t s2_sqx_q, s2_sqy_q;

  logic s3_v_q, s3_last_q;
  logic s4_v_q, s4_done_q;
  verdict_e s4_verdict_d, s4_verdict_q;

  logic s1_adv, s2_adv, s3_adv, in_acc, out_acc;
  logic ex_x, ex_y;

  sqr_t    x_sq, y_sq;
  sum_t    new_x, new_y;
  sum_sq_t new_sqx, new_sqy;
  cnt_t    new_cnt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_x_q <= ThrReset;
      thr_y_q <= ThrReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD_X: thr_x_q <= cfg_data_i;
        CFG_THRESHOLD_Y: thr_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_acc    = s4_v_q && !out_stall_i;
  assign s3_adv     = s3_v_q && (!s4_v_q || !out_stall_i);
  assign s2_adv     = s2_v_q && (!s3_v_q || s3_adv);
  assign s1_adv     = s1_v_q && (!s2_v_q || s2_adv);
  assign in_stall_o = s1_v_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_q <= 1'b1;
      end else if (s2_adv) begin
        s2_v_q <= 1'b0;
      end
      if (s2_adv) begin
        s3_v_q <= 1'b1;
      end else if (s3_adv) begin
        s3_v_q <= 1'b0;
      end
      if (s3_adv) begin
        s4_v_q <= 1'b1;
      end else if (out_acc) begin
        s4_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_found_q <= face_found_i;
      s1_x_q     <= face_x_i;
      s1_y_q     <= face_y_i;
    end
  end

  assign x_sq    = sqr_t'(s1_x_q) * sqr_t'(s1_x_q);
  assign y_sq    = sqr_t'(s1_y_q) * sqr_t'(s1_y_q);
  assign new_x   = acc_x_q + sum_t'(s1_x_q);
  assign new_y   = acc_y_q + sum_t'(s1_y_q);
  assign new_sqx = acc_sqx_q + sum_sq_t'(x_sq);
  assign new_sqy = acc_sqy_q + sum_sq_t'(y_sq);
  assign new_cnt = cnt_q + cnt_t'(1);

  always_comb begin
    cnt_d     = cnt_q;
    acc_x_d   = acc_x_q;
    acc_y_d   = acc_y_q;
    acc_sqx_d = acc_sqx_q;
    acc_sqy_d = acc_sqy_q;
    s2_last_d = 1'b0;
    if (s1_found_q) begin
      if (new_cnt == cnt_t'(WINDOW_LENGTH)) begin
        s2_last_d = 1'b1;
        cnt_d     = '0;
        acc_x_d   = '0;
        acc_y_d   = '0;
        acc_sqx_d = '0;
        acc_sqy_d = '0;
      end else begin
        cnt_d     = new_cnt;
        acc_x_d   = new_x;
        acc_y_d   = new_y;
        acc_sqx_d = new_sqx;
        acc_sqy_d = new_sqy;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      acc_x_q   <= '0;
      acc_y_q   <= '0;
      acc_sqx_q <= '0;
      acc_sqy_q <= '0;
      s2_last_q <= 1'b0;
      s3_last_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        cnt_q     <= cnt_d;
        acc_x_q   <= acc_x_d;
        acc_y_q   <= acc_y_d;
        acc_sqx_q <= acc_sqx_d;
        acc_sqy_q <= acc_sqy_d;
        s2_last_q <= s2_last_d;
      end
      if (s2_adv) begin
        s3_last_q <= s2_last_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_x_q   <= new_x;
      s2_y_q   <= new_y;
      s2_sqx_q <= new_sqx;
      s2_sqy_q <= new_sqy;
    end
  end

  wvnc_axis_test u_axis_x (
    .clk_i     (clk_i),
    .load_i    (s2_adv),
    .sum_i     (s2_x_q),
    .sum_sq_i  (s2_sqx_q),
    .thr_i     (thr_x_q),
    .exceeds_o (ex_x)
  );

  wvnc_axis_test u_axis_y (
    .clk_i     (clk_i),
    .load_i    (s2_adv),
    .sum_i     (s2_y_q),
    .sum_sq_i  (s2_sqy_q),
    .thr_i     (thr_y_q),
    .exceeds_o (ex_y)
  );

  always_comb begin
    s4_verdict_d = VERDICT_NONE;
    if (s3_last_q) begin
      if (ex_x) begin
        s4_verdict_d = VERDICT_NO;
      end else if (ex_y) begin
        s4_verdict_d = VERDICT_YES;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_adv) begin
      s4_verdict_q <= s4_verdict_d;
      s4_done_q    <= s3_last_q;
    end
  end

  assign out_valid_o   = s4_v_q;
  assign verdict_o     = s4_verdict_q;
  assign window_done_o = s4_done_q;

endmodule
